// ----- src/ubx_nav_frame_parser_assert.svh -----
// Assertion macros used by the frame parser port checker.
`ifndef UBX_NAV_FRAME_PARSER_ASSERT_SVH
`define UBX_NAV_FRAME_PARSER_ASSERT_SVH

// same-cycle implication, masked during reset
`define UNPF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame parser assertion failed");

// next-cycle implication, masked during reset
`define UNPF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame parser assertion failed");

// next-cycle implication, also checked across reset
`define UNPF_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("frame parser assertion failed");

`endif

// ----- src/unpf_pkg.sv -----
// Shared constants, types and helper functions of the frame parser.
`timescale 1ns / 1ps
package unpf_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;
  localparam logic [7:0] ID_POSLLH   = 8'h02;
  localparam logic [7:0] ID_STATUS   = 8'h03;
  localparam logic [7:0] ID_SOL      = 8'h06;
  localparam logic [7:0] ID_VELNED   = 8'h12;
  localparam logic [6:0] MAX_LEN_RESET = 7'd70;

  // payload offsets that any decoder reads: 4..11, 16..27, 47
  localparam int SLOT_COUNT = 21;
  localparam int SLOT_LON       = 0;   // offset 4
  localparam int SLOT_STAT_TYPE = 0;   // offset 4
  localparam int SLOT_STAT_FLAG = 1;   // offset 5
  localparam int SLOT_LAT       = 4;   // offset 8
  localparam int SLOT_SOL_TYPE  = 6;   // offset 10
  localparam int SLOT_SOL_FLAG  = 7;   // offset 11
  localparam int SLOT_HMSL      = 8;   // offset 16
  localparam int SLOT_SPEED     = 12;  // offset 20
  localparam int SLOT_HEADING   = 16;  // offset 24
  localparam int SLOT_NUMSV     = 20;  // offset 47

  localparam int QUEUE_DEPTH = 2;

  // reciprocal constants: x/1000 and (x>>4)/625
  localparam logic [31:0] DIV1000_MAGIC = 32'd2199023256;
  localparam int          DIV1000_SHIFT = 41;
  localparam int          DIV10000_PRE  = 4;
  localparam logic [28:0] DIV625_MAGIC  = 29'd439804652;
  localparam int          DIV625_SHIFT  = 38;

  typedef logic [4:0] slot_idx_t;

  typedef struct packed {
    logic [7:0]                       id;
    logic [SLOT_COUNT-1:0][7:0]       slot;
  } frame_t;

  typedef struct packed {
    logic      hit;
    slot_idx_t idx;
  } slot_map_t;

  function automatic slot_map_t slot_of(input logic [6:0] pos);
    slot_map_t m;
    m.hit = 1'b1;
    m.idx = '0;
    if (pos >= 7'd4 && pos <= 7'd11) begin
      m.idx = 5'(pos - 7'd4);
    end else if (pos >= 7'd16 && pos <= 7'd27) begin
      m.idx = 5'(pos - 7'd8);
    end else if (pos == 7'd47) begin
      m.idx = 5'(SLOT_NUMSV);
    end else begin
      m.hit = 1'b0;
    end
    return m;
  endfunction

  function automatic logic [31:0] word_at(input frame_t f, input int base);
    return {f.slot[base+3], f.slot[base+2], f.slot[base+1], f.slot[base]};
  endfunction

  function automatic logic fix_ok(input logic [7:0] kind_code, input logic [7:0] flags);
    return flags[0] && (kind_code == 8'd2 || kind_code == 8'd3);
  endfunction

endpackage

// ----- src/unpf_if.sv -----
// Valid/ready channel interfaces for received bytes and decoded results.
`timescale 1ns / 1ps
interface unpf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface unpf_out_if;
  logic               valid;
  logic               ready;
  logic               msg_recognized;
  logic               fresh_pos_and_vel;
  logic signed [31:0] latitude;
  logic signed [31:0] longitude;
  logic signed [22:0] altitude_m;
  logic               fix_valid;
  logic [7:0]         satellites;
  logic [31:0]        ground_speed;
  logic [15:0]        ground_course;
  modport source (output valid, output msg_recognized, output fresh_pos_and_vel,
                  output latitude, output longitude, output altitude_m,
                  output fix_valid, output satellites, output ground_speed,
                  output ground_course, input ready);
  modport sink   (input valid, input msg_recognized, input fresh_pos_and_vel,
                  input latitude, input longitude, input altitude_m,
                  input fix_valid, input satellites, input ground_speed,
                  input ground_course, output ready);
endinterface

// ----- src/unpf_front.sv -----
// Byte-level frame tracker: sync hunt, header, payload capture, checksum.
`timescale 1ns / 1ps
module unpf_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [6:0]       cfg_wdata,
  input  logic             byte_valid,
  input  logic [7:0]       byte_data,
  output logic             byte_ready,
  input  logic             push_room,
  output logic             push_valid,
  output unpf_pkg::frame_t push_frame
);
  import unpf_pkg::*;

  localparam logic [3:0] ST_HUNT    = 4'd0;
  localparam logic [3:0] ST_SYNC2   = 4'd1;
  localparam logic [3:0] ST_CLASS   = 4'd2;
  localparam logic [3:0] ST_ID      = 4'd3;
  localparam logic [3:0] ST_LEN_LO  = 4'd4;
  localparam logic [3:0] ST_LEN_HI  = 4'd5;
  localparam logic [3:0] ST_PAYLOAD = 4'd6;
  localparam logic [3:0] ST_CK_A    = 4'd7;
  localparam logic [3:0] ST_CK_B    = 4'd8;

  logic [3:0]  step_r, step_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [7:0]  len_lo_r, len_lo_nxt;
  logic [6:0]  len_r, len_nxt;
  logic [6:0]  count_r, count_nxt;
  logic [6:0]  max_len_r;
  logic [SLOT_COUNT-1:0][7:0] slot_r, slot_nxt;
  logic        accept;
  logic [7:0]  add_a, add_b;
  logic [6:0]  count_inc;
  logic [3:0]  hunt_step;
  slot_map_t   map;

  assign byte_ready = push_room;
  assign accept     = byte_valid && byte_ready;
  assign add_a      = sum_a_r + byte_data;
  assign add_b      = sum_b_r + add_a;
  assign count_inc  = count_r + 7'd1;
  assign hunt_step  = (byte_data == SYNC_FIRST) ? ST_SYNC2 : ST_HUNT;
  assign map        = slot_of(count_r);

  assign push_valid       = accept && (step_r == ST_CK_B) && (byte_data == sum_b_r);
  assign push_frame.id    = id_r;
  assign push_frame.slot  = slot_r;

  always_comb begin
    step_nxt   = step_r;
    sum_a_nxt  = sum_a_r;
    sum_b_nxt  = sum_b_r;
    id_nxt     = id_r;
    len_lo_nxt = len_lo_r;
    len_nxt    = len_r;
    count_nxt  = count_r;
    slot_nxt   = slot_r;
    unique case (step_r)
      ST_SYNC2: begin
        step_nxt = (byte_data == SYNC_SECOND) ? ST_CLASS : hunt_step;
      end
      ST_CLASS: begin
        sum_a_nxt = byte_data;
        sum_b_nxt = byte_data;
        step_nxt  = ST_ID;
      end
      ST_ID: begin
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        id_nxt    = byte_data;
        step_nxt  = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        sum_a_nxt  = add_a;
        sum_b_nxt  = add_b;
        len_lo_nxt = byte_data;
        step_nxt   = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        if ({byte_data, len_lo_r} > {9'd0, max_len_r}) begin
          step_nxt = hunt_step;
        end else begin
          count_nxt = '0;
          len_nxt   = len_lo_r[6:0];
          step_nxt  = (len_lo_r == 8'd0) ? ST_CK_A : ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        if (map.hit) slot_nxt[map.idx] = byte_data;
        count_nxt = count_inc;
        if (count_inc == len_r) step_nxt = ST_CK_A;
      end
      ST_CK_A: begin
        step_nxt = (byte_data != sum_a_r) ? hunt_step : ST_CK_B;
      end
      ST_CK_B: begin
        step_nxt = ST_HUNT;
      end
      default: begin
        step_nxt = hunt_step;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= ST_HUNT;
      sum_a_r   <= '0;
      sum_b_r   <= '0;
      id_r      <= '0;
      len_lo_r  <= '0;
      len_r     <= '0;
      count_r   <= '0;
      slot_r    <= '0;
      max_len_r <= MAX_LEN_RESET;
    end else begin
      if (cfg_we) max_len_r <= cfg_wdata;
      if (accept) begin
        step_r   <= step_nxt;
        sum_a_r  <= sum_a_nxt;
        sum_b_r  <= sum_b_nxt;
        id_r     <= id_nxt;
        len_lo_r <= len_lo_nxt;
        len_r    <= len_nxt;
        count_r  <= count_nxt;
        slot_r   <= slot_nxt;
      end
    end
  end

endmodule

// ----- src/unpf_queue.sv -----
// Short frame queue between the byte tracker and the decoder.
`timescale 1ns / 1ps
module unpf_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  unpf_pkg::frame_t push_data,
  output logic             room,
  input  logic             pop,
  output logic             avail,
  output unpf_pkg::frame_t pop_data
);
  import unpf_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  frame_t              mem_r [QUEUE_DEPTH];
  logic [PW-1:0]       wr_r, rd_r;
  logic [PW:0]         cnt_r;

  assign room     = (cnt_r != (PW+1)'(QUEUE_DEPTH));
  assign avail    = (cnt_r != '0);
  assign pop_data = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == PW'(QUEUE_DEPTH-1)) ? '0 : wr_r + PW'(1);
      if (pop)  rd_r <= (rd_r == PW'(QUEUE_DEPTH-1)) ? '0 : rd_r + PW'(1);
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (PW+1)'(1);
        2'b01:   cnt_r <= cnt_r - (PW+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- src/unpf_back.sv -----
// Message decoder: scaled divides, held navigation state, result register.
`timescale 1ns / 1ps
module unpf_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_avail,
  input  unpf_pkg::frame_t q_data,
  output logic             q_pop,
  unpf_out_if.source       out_if
);
  import unpf_pkg::*;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_MUL  = 2'd1;
  localparam logic [1:0] B_FIN  = 2'd2;

  logic [1:0]  state_r;
  frame_t      frm_r;
  logic        alt_neg_r, crs_neg_r;
  logic [31:0] alt_mag_r, crs_mag_r;
  logic [63:0] alt_prod_r;
  logic [56:0] crs_prod_r;
  logic [31:0] alt_raw, crs_raw;
  logic [21:0] alt_q;
  logic [15:0] crs_q;
  logic [22:0] alt_val;
  logic [15:0] crs_val;
  logic        load;

  logic        valid_r, recog_r, fresh_r;
  logic        pend_fix_r, fix_r, pos_mark_r, vel_mark_r;
  logic [31:0] lat_r, lon_r, speed_r;
  logic [22:0] alt_r;
  logic [7:0]  sats_r;
  logic [15:0] course_r;

  logic        recog_nxt, fresh_nxt, pend_fix_nxt, fix_nxt, pos_mark_nxt, vel_mark_nxt;
  logic [31:0] lat_nxt, lon_nxt, speed_nxt;
  logic [22:0] alt_nxt;
  logic [7:0]  sats_nxt;
  logic [15:0] course_nxt;
  logic        ok_tmp;

  assign alt_raw = word_at(q_data, SLOT_HMSL);
  assign crs_raw = word_at(q_data, SLOT_HEADING);
  assign q_pop   = (state_r == B_IDLE) && q_avail;
  assign load    = (state_r == B_FIN) && (!valid_r || out_if.ready);

  assign alt_q   = alt_prod_r[DIV1000_SHIFT+21:DIV1000_SHIFT];
  assign crs_q   = crs_prod_r[DIV625_SHIFT+15:DIV625_SHIFT];
  assign alt_val = alt_neg_r ? (23'd0 - {1'b0, alt_q}) : {1'b0, alt_q};
  assign crs_val = crs_neg_r ? (16'd0 - crs_q) : crs_q;

  always_comb begin
    recog_nxt    = 1'b1;
    fresh_nxt    = 1'b0;
    pend_fix_nxt = pend_fix_r;
    fix_nxt      = fix_r;
    pos_mark_nxt = pos_mark_r;
    vel_mark_nxt = vel_mark_r;
    lat_nxt      = lat_r;
    lon_nxt      = lon_r;
    alt_nxt      = alt_r;
    sats_nxt     = sats_r;
    speed_nxt    = speed_r;
    course_nxt   = course_r;
    ok_tmp       = 1'b0;
    unique case (frm_r.id)
      ID_POSLLH: begin
        lon_nxt      = word_at(frm_r, SLOT_LON);
        lat_nxt      = word_at(frm_r, SLOT_LAT);
        alt_nxt      = alt_val;
        fix_nxt      = pend_fix_r;
        pos_mark_nxt = 1'b1;
      end
      ID_STATUS: begin
        ok_tmp       = fix_ok(frm_r.slot[SLOT_STAT_TYPE], frm_r.slot[SLOT_STAT_FLAG]);
        pend_fix_nxt = ok_tmp;
        if (!ok_tmp) fix_nxt = 1'b0;
      end
      ID_SOL: begin
        ok_tmp       = fix_ok(frm_r.slot[SLOT_SOL_TYPE], frm_r.slot[SLOT_SOL_FLAG]);
        pend_fix_nxt = ok_tmp;
        if (!ok_tmp) fix_nxt = 1'b0;
        sats_nxt     = frm_r.slot[SLOT_NUMSV];
      end
      ID_VELNED: begin
        speed_nxt    = word_at(frm_r, SLOT_SPEED);
        course_nxt   = crs_val;
        vel_mark_nxt = 1'b1;
      end
      default: begin
        recog_nxt = 1'b0;
      end
    endcase
    if (recog_nxt && pos_mark_nxt && vel_mark_nxt) begin
      pos_mark_nxt = 1'b0;
      vel_mark_nxt = 1'b0;
      fresh_nxt    = 1'b1;
    end
  end

  // datapath pipeline: magnitudes, then reciprocal products
  always_ff @(posedge clk) begin
    if (q_pop) begin
      frm_r     <= q_data;
      alt_neg_r <= alt_raw[31];
      crs_neg_r <= crs_raw[31];
      alt_mag_r <= alt_raw[31] ? (32'd0 - alt_raw) : alt_raw;
      crs_mag_r <= crs_raw[31] ? (32'd0 - crs_raw) : crs_raw;
    end
    if (state_r == B_MUL) begin
      alt_prod_r <= alt_mag_r * DIV1000_MAGIC;
      crs_prod_r <= crs_mag_r[31:DIV10000_PRE] * DIV625_MAGIC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= B_IDLE;
      valid_r    <= 1'b0;
      recog_r    <= 1'b0;
      fresh_r    <= 1'b0;
      pend_fix_r <= 1'b0;
      fix_r      <= 1'b0;
      pos_mark_r <= 1'b0;
      vel_mark_r <= 1'b0;
      lat_r      <= '0;
      lon_r      <= '0;
      alt_r      <= '0;
      sats_r     <= '0;
      speed_r    <= '0;
      course_r   <= '0;
    end else begin
      unique case (state_r)
        B_IDLE:  if (q_pop) state_r <= B_MUL;
        B_MUL:   state_r <= B_FIN;
        B_FIN:   if (load) state_r <= B_IDLE;
        default: state_r <= B_IDLE;
      endcase
      if (load) begin
        valid_r    <= 1'b1;
        recog_r    <= recog_nxt;
        fresh_r    <= fresh_nxt;
        pend_fix_r <= pend_fix_nxt;
        fix_r      <= fix_nxt;
        pos_mark_r <= pos_mark_nxt;
        vel_mark_r <= vel_mark_nxt;
        lat_r      <= lat_nxt;
        lon_r      <= lon_nxt;
        alt_r      <= alt_nxt;
        sats_r     <= sats_nxt;
        speed_r    <= speed_nxt;
        course_r   <= course_nxt;
      end else if (out_if.ready) begin
        valid_r    <= 1'b0;
      end
    end
  end

  assign out_if.valid             = valid_r;
  assign out_if.msg_recognized    = recog_r;
  assign out_if.fresh_pos_and_vel = fresh_r;
  assign out_if.latitude          = lat_r;
  assign out_if.longitude         = lon_r;
  assign out_if.altitude_m        = alt_r;
  assign out_if.fix_valid         = fix_r;
  assign out_if.satellites        = sats_r;
  assign out_if.ground_speed      = speed_r;
  assign out_if.ground_course     = course_r;

endmodule

// ----- src/ubx_nav_frame_parser.sv -----
// Top level of the navigation frame parser: tracker, frame queue, decoder.
// Throughput: one received word per cycle; in_if.ready drops only while the
//   two-entry frame queue is full (decoder stalled by the result consumer).
// Path: after the second checksum word is taken, a frame passes the queue write,
//   decoder magnitude stage, reciprocal multiply stage and result register.
// Reset (rst_n low, synchronous): hunting for sync, sums/marks/held fields 0,
//   payload length limit 70, no result pending.
`timescale 1ns / 1ps
module ubx_nav_frame_parser (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata,
  unpf_in_if.sink    in_if,
  unpf_out_if.source out_if
);
  import unpf_pkg::*;

  // tracker -> queue
  logic   push_valid, push_room;
  frame_t push_frame;
  // queue -> decoder
  logic   q_avail, q_pop;
  frame_t q_data;

  // Front: walks each word through sync, header, payload and both checksum
  // bytes; keeps only the payload offsets that a decoder reads.
  unpf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .byte_valid (in_if.valid),
    .byte_data  (in_if.rx_byte),
    .byte_ready (in_if.ready),
    .push_room  (push_room),
    .push_valid (push_valid),
    .push_frame (push_frame)
  );

  // Checked frames wait here so header parsing waits on the decoder only while the queue is full.
  unpf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_data (push_frame),
    .room      (push_room),
    .pop       (q_pop),
    .avail     (q_avail),
    .pop_data  (q_data)
  );

  // Back: decode by id, divide altitude/heading, update held fields.
  unpf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_avail (q_avail),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

endmodule

// ----- src/unpf_chk.sv -----
// Port-level checker for the frame parser, bound to the top level.
`timescale 1ns / 1ps
`include "ubx_nav_frame_parser_assert.svh"
module unpf_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_recog,
  input logic        out_fresh,
  input logic [31:0] out_lat
);
  `UNPF_ASSERT_NEXT(a_valid_hold, out_valid && !out_ready, out_valid)
  `UNPF_ASSERT_NEXT(a_lat_hold, out_valid && !out_ready, $stable(out_lat))
  `UNPF_ASSERT_SAME(a_fresh_recog, out_valid && out_fresh, out_recog)
  `UNPF_ASSERT_RST(a_reset_quiet, !rst_n, !out_valid)
endmodule

bind ubx_nav_frame_parser unpf_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_recog (out_if.msg_recognized),
  .out_fresh (out_if.fresh_pos_and_vel),
  .out_lat   (out_if.latitude)
);

// ----- bench/frame_checker.sv -----
// Checker for the frame parser: predicts decoded results from accepted words and compares them.
`timescale 1ns / 1ps
module frame_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata,
  unpf_in_if         in_mon,
  unpf_out_if        out_mon,
  output int         fails,
  output int         pending
);
  import unpf_pkg::*;

  typedef struct {
    logic        recognized;
    logic        fresh;
    logic [31:0] lat;
    logic [31:0] lon;
    logic [22:0] alt;
    logic        fix;
    logic [7:0]  sats;
    logic [31:0] speed;
    logic [15:0] course;
  } nav_result_t;

  localparam int STORE_BYTES = 80;

  nav_result_t nav_q[$];

  logic [6:0]  len_limit;
  logic [3:0]  step;
  logic [7:0]  ck_a, ck_b, msg_id;
  logic [15:0] pay_len;
  logic [6:0]  pay_cnt;
  logic [7:0]  store[STORE_BYTES];
  logic        pend_fix, fix_q, pos_mark, vel_mark;
  logic [31:0] lat_q, lon_q, speed_q;
  logic [22:0] alt_q;
  logic [7:0]  sats_q;
  logic [15:0] course_q;

  function automatic logic [7:0] byte_at(int pos);
    return (pos < STORE_BYTES) ? store[pos] : 8'h00;
  endfunction

  function automatic logic [31:0] le32(int pos);
    return {byte_at(pos + 3), byte_at(pos + 2), byte_at(pos + 1), byte_at(pos)};
  endfunction

  // signed quotient, truncated toward zero
  function automatic logic [31:0] sdiv(logic [31:0] v, int d);
    longint s;
    s = longint'($signed(v)) / d;
    return s[31:0];
  endfunction

  function automatic logic fix_good(logic [7:0] ft, logic [7:0] fl);
    return fl[0] && (ft == 8'd2 || ft == 8'd3);
  endfunction

  task automatic sync_hunt(logic [7:0] b);
    step = (b == SYNC_FIRST) ? 4'd1 : 4'd0;
  endtask

  task automatic sum_in(logic [7:0] b);
    ck_a = ck_a + b;
    ck_b = ck_b + ck_a;
  endtask

  // advance the parser by one word; push a result on a good frame
  task automatic track_word(logic [7:0] b);
    nav_result_t r;
    logic rec;
    rec = 1'b1;
    case (step)
      4'd1: if (b == SYNC_SECOND) step = 4'd2; else sync_hunt(b);
      4'd2: begin
        ck_a = b; ck_b = b; step = 4'd3;
      end
      4'd3: begin
        sum_in(b); msg_id = b; step = 4'd4;
      end
      4'd4: begin
        sum_in(b); pay_len = {8'h00, b}; step = 4'd5;
      end
      4'd5: begin
        sum_in(b);
        pay_len[15:8] = b;
        if (pay_len > {9'd0, len_limit}) begin
          pay_len = '0;
          sync_hunt(b);
        end else begin
          pay_cnt = '0;
          step = (pay_len == 16'd0) ? 4'd7 : 4'd6;
        end
      end
      4'd6: begin
        sum_in(b);
        if (pay_cnt < STORE_BYTES) store[pay_cnt] = b;
        pay_cnt = pay_cnt + 7'd1;
        if ({9'd0, pay_cnt} == pay_len) step = 4'd7;
      end
      4'd7: if (b != ck_a) sync_hunt(b); else step = 4'd8;
      4'd8: begin
        step = 4'd0;
        if (b == ck_b) begin
          r.fresh = 1'b0;
          case (msg_id)
            ID_POSLLH: begin
              lon_q = le32(4);
              lat_q = le32(8);
              alt_q = 23'(sdiv(le32(16), 1000));
              fix_q = pend_fix;
              pos_mark = 1'b1;
            end
            ID_STATUS: begin
              pend_fix = fix_good(byte_at(4), byte_at(5));
              if (!pend_fix) fix_q = 1'b0;
            end
            ID_SOL: begin
              pend_fix = fix_good(byte_at(10), byte_at(11));
              if (!pend_fix) fix_q = 1'b0;
              sats_q = byte_at(47);
            end
            ID_VELNED: begin
              speed_q = le32(20);
              course_q = 16'(sdiv(le32(24), 10000));
              vel_mark = 1'b1;
            end
            default: rec = 1'b0;
          endcase
          if (rec && pos_mark && vel_mark) begin
            pos_mark = 1'b0; vel_mark = 1'b0; r.fresh = 1'b1;
          end
          r.recognized = rec;
          r.lat = lat_q; r.lon = lon_q; r.alt = alt_q; r.fix = fix_q;
          r.sats = sats_q; r.speed = speed_q; r.course = course_q;
          nav_q.push_back(r);
        end
      end
      default: sync_hunt(b);
    endcase
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    nav_result_t e;
    if (!rst_n) begin
      fails = 0;
      len_limit = MAX_LEN_RESET;
      step = '0; ck_a = '0; ck_b = '0; msg_id = '0; pay_len = '0; pay_cnt = '0;
      foreach (store[i]) store[i] = '0;
      pend_fix = 0; fix_q = 0; pos_mark = 0; vel_mark = 0;
      lat_q = '0; lon_q = '0; alt_q = '0; sats_q = '0; speed_q = '0; course_q = '0;
      nav_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (nav_q.size() == 0) begin
          $display("%0t mismatch: result with none expected, actual lat %h", $time,
                   out_mon.latitude);
          fails++;
        end else begin
          e = nav_q.pop_front();
          check_field("msg_recognized", e.recognized, out_mon.msg_recognized);
          check_field("fresh_pos_and_vel", e.fresh, out_mon.fresh_pos_and_vel);
          check_field("latitude", e.lat, out_mon.latitude);
          check_field("longitude", e.lon, out_mon.longitude);
          check_field("altitude_m", {9'd0, e.alt}, {9'd0, out_mon.altitude_m});
          check_field("fix_valid", e.fix, out_mon.fix_valid);
          check_field("satellites", e.sats, out_mon.satellites);
          check_field("ground_speed", e.speed, out_mon.ground_speed);
          check_field("ground_course", e.course, out_mon.ground_course);
        end
      end
      if (in_mon.valid && in_mon.ready) track_word(in_mon.rx_byte);
      if (cfg_we) len_limit = cfg_wdata;
    end
    pending = nav_q.size();
  end

endmodule

// ----- bench/testbench.sv -----
// Top of the frame parser bench: clock, reset, frame stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  import unpf_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [6:0] cfg_wdata;
  int         fails;
  int         pending;
  int         snd_idle;   // percent of cycles the sender idles
  int         rcv_idle;   // percent of cycles the receiver stalls
  logic       hold_off;   // long receiver stall to fill the frame queue
  int         cycles = 0;
  int         words_sent;

  unpf_in_if  in_ch ();
  unpf_out_if out_ch ();

  ubx_nav_frame_parser i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_if    (in_ch),
    .out_if   (out_ch)
  );

  frame_checker i_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_mon   (in_ch),
    .out_mon  (out_ch),
    .fails    (fails),
    .pending  (pending)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // watchdog: well above the slowest legal run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("testbench failed");
      $finish;
    end
  end

  // receiver: random stalls, plus the long hold-off
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= !hold_off && ($urandom_range(99) >= rcv_idle);
  end

  // hold-off runs in its own process while the sender keeps pushing frames
  initial begin
    hold_off = 1'b0;
    repeat (800) @(posedge clk);
    hold_off <= 1'b1;
    repeat (500) @(posedge clk);
    hold_off <= 1'b0;
  end

  // one word over the input channel; ready is sampled at the falling edge
  task automatic send_word(logic [7:0] b);
    while ($urandom_range(99) < snd_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    words_sent++;
  endtask

  // frame kinds
  typedef enum int {FR_GOOD, FR_BAD_A, FR_BAD_B, FR_LONG, FR_NO_SYNC2} frame_kind_t;

  task automatic send_frame(logic [7:0] id, logic [15:0] len, frame_kind_t kind,
                            int fill);
    logic [7:0] pl[$];
    logic [7:0] hdr[4];
    logic [7:0] a, b, v;
    a = 0; b = 0;
    hdr[0] = 8'($urandom_range(255)); hdr[1] = id; hdr[2] = len[7:0]; hdr[3] = len[15:8];
    for (int i = 0; i < len; i++) begin
      // fill: 0 random, 1 all zeros, 2 all ones
      v = (fill == 1) ? 8'h00 : (fill == 2) ? 8'hFF : 8'($urandom_range(255));
      pl.push_back(v);
    end
    // steer fix type and flags so a valid fix shows up often
    if (fill == 0 && $urandom_range(3) != 0) begin
      if (id == ID_STATUS && len > 5) begin
        pl[4] = 8'($urandom_range(1, 4)); pl[5][0] = $urandom_range(3) != 0;
      end
      if (id == ID_SOL && len > 11) begin
        pl[10] = 8'($urandom_range(1, 4)); pl[11][0] = $urandom_range(3) != 0;
      end
    end
    foreach (hdr[i]) begin a += hdr[i]; b += a; end
    foreach (pl[i])  begin a += pl[i];  b += a; end
    send_word(SYNC_FIRST);
    if (kind == FR_NO_SYNC2) begin
      // second sync missing; the stray word may itself start a frame
      send_word($urandom_range(1) ? SYNC_FIRST : 8'($urandom_range(255)));
    end
    send_word(SYNC_SECOND);
    foreach (hdr[i]) send_word(hdr[i]);
    if (kind == FR_LONG) return;
    foreach (pl[i]) send_word(pl[i]);
    send_word(kind == FR_BAD_A ? a ^ 8'($urandom_range(1, 255)) : a);
    send_word(kind == FR_BAD_B ? b ^ 8'($urandom_range(1, 255)) : b);
  endtask

  function automatic logic [15:0] full_len(logic [7:0] id);
    case (id)
      ID_POSLLH: return 16'd28;
      ID_STATUS: return 16'd16;
      ID_SOL:    return 16'd52;
      ID_VELNED: return 16'd36;
      default:   return 16'($urandom_range(0, 20));
    endcase
  endfunction

  task automatic idle_then_config(logic [6:0] v);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_frame(logic [6:0] lim);
    logic [7:0]  ids[4];
    logic [7:0]  id;
    logic [15:0] len;
    int          pick;
    ids = '{ID_POSLLH, ID_STATUS, ID_SOL, ID_VELNED};
    pick = $urandom_range(99);
    id = ids[$urandom_range(3)];
    len = ($urandom_range(9) < 7) ? full_len(id) : 16'($urandom_range(0, 80));
    if (len > lim && $urandom_range(3) != 0) len = lim;  // mostly keep it legal
    if (pick < 72)      send_frame(id, len, FR_GOOD, 0);
    else if (pick < 80) send_frame(8'($urandom_range(255)), 16'($urandom_range(0, lim)),
                                   FR_GOOD, 0);
    else if (pick < 85) send_frame(id, len, FR_BAD_A, 0);
    else if (pick < 90) send_frame(id, len, FR_BAD_B, 0);
    else if (pick < 94) send_frame(id, 16'(lim) + 16'($urandom_range(1, 65000)),
                                   FR_LONG, 0);
    else if (pick < 97) send_frame(id, len, FR_NO_SYNC2, 0);
    else repeat ($urandom_range(1, 6)) send_word(8'($urandom_range(255)));
  endtask

  initial begin
    logic [6:0] limits[6];
    limits = '{7'd80, 7'd0, 7'd52, 7'd0, 7'd36, 7'd80};
    limits[3] = 7'($urandom_range(0, 80));
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = '0;
    snd_idle = 13;
    rcv_idle = 46;
    words_sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset limit 70, every message, the odd cases
    send_frame(ID_POSLLH, 16'd28, FR_GOOD, 0);  // full length, first frame after reset
    send_frame(ID_VELNED, 16'd20, FR_GOOD, 0);  // short: speed from store
    send_frame(ID_POSLLH, 16'd28, FR_GOOD, 2);  // all ones: every word reads as -1
    send_frame(ID_VELNED, 16'd36, FR_GOOD, 2);
    send_frame(ID_STATUS, 16'd16, FR_GOOD, 0);
    send_frame(ID_SOL, 16'd52, FR_GOOD, 0);
    send_frame(ID_POSLLH, 16'd28, FR_GOOD, 1);
    send_frame(ID_VELNED, 16'd36, FR_GOOD, 0);
    send_frame(ID_STATUS, 16'd0, FR_GOOD, 0);   // zero length
    send_frame(8'h55, 16'd5, FR_GOOD, 0);       // unknown id
    send_frame(ID_SOL, 16'd71, FR_LONG, 0);     // just over the limit
    send_frame(ID_SOL, 16'd70, FR_GOOD, 0);     // at the limit
    send_frame(ID_POSLLH, 16'd28, FR_BAD_A, 0);
    send_frame(ID_POSLLH, 16'd28, FR_BAD_B, 0);
    send_frame(ID_VELNED, 16'd36, FR_NO_SYNC2, 0);
    send_word(SYNC_FIRST);                      // extra sync word ahead of the next frame
    send_frame(8'hFF, 16'hB5B5, FR_LONG, 0);    // length high word is a sync
    send_frame(ID_STATUS, 16'd16, FR_GOOD, 0);

    for (int p = 0; p < 6; p++) begin
      idle_then_config(limits[p]);
      snd_idle = (p < 2) ? 13 : (p < 4) ? 46 : 0;
      rcv_idle = (p < 2) ? 46 : (p < 4) ? 13 : 0;
      while (words_sent < 560 + 130 * (p + 1)) random_frame(limits[p]);
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
